// ----- hw/rtl/tcs_pkg.sv -----
// Shared types and constants for the track chord block.
// No dependencies; used by the front, both cell types and the top level.
`timescale 1ns / 1ps
`default_nettype none
package tcs_pkg;
  localparam int unsigned LANES = 3;   // distance, inner chord, outer chord
  localparam int unsigned NW    = 54;  // dividend width
  localparam int unsigned QW    = 30;  // clamped quotient width
  localparam int unsigned SW    = 24;  // |d|^2 width
  localparam int unsigned RW    = 31;  // root remainder width
  localparam int unsigned RTW   = 15;  // root steps
  localparam int unsigned LW    = 15;  // output length width
  localparam int unsigned FRONT_LAT = 6;
  localparam int unsigned CORE_LAT  = FRONT_LAT + QW + RTW;

  localparam logic       REG_INNER = 1'b0;
  localparam logic       REG_OUTER = 1'b1;
  localparam logic [9:0] INNER_RESET = 10'd650;
  localparam logic [9:0] OUTER_RESET = 10'd830;

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [QW-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [RW-1:0] res;
  } root_lane_t;
endpackage
`default_nettype wire

// ----- hw/rtl/tcs_front.sv -----
// Front arithmetic: cross product, norms, radius products, dividends.
// Depends on tcs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcs_front (
  input  wire                              clk_i,
  input  wire                              en_i,
  input  wire  signed [10:0]               px_i,
  input  wire  signed [10:0]               py_i,
  input  wire  signed [10:0]               pz_i,
  input  wire  signed [11:0]               dx_i,
  input  wire  signed [11:0]               dy_i,
  input  wire  signed [11:0]               dz_i,
  input  wire         [9:0]                ri_i,
  input  wire         [9:0]                ro_i,
  output tcs_pkg::div_lane_t [tcs_pkg::LANES-1:0] lanes_o,
  output logic        [tcs_pkg::SW-1:0]    s_o,
  output logic                             zero_o
);
  import tcs_pkg::*;

  logic signed [22:0] pyz_q, pzy_q, pzx_q, pxz_q, pxy_q, pyx_q;
  logic        [22:0] sqx_q, sqy_q, sqz_q;
  logic signed [23:0] sqx_w, sqy_w, sqz_w;
  logic signed [23:0] cx_q, cy_q, cz_q;
  logic [SW-1:0] sb_q, sc_q, sd_q, se_q;
  logic signed [47:0] cxx_w, cyy_w, czz_w;
  logic [43:0] cxx_q, cyy_q, czz_q;
  logic [19:0] ri2_q, ro2_q;
  logic [45:0] c_q;
  logic [43:0] rsi_q, rso_q;
  logic [NW-1:0] nd_q, ni_q, no_q, lim;
  logic [NW-1:0] dvd [LANES];

  assign sqx_w = dx_i * dx_i;
  assign sqy_w = dy_i * dy_i;
  assign sqz_w = dz_i * dz_i;
  assign cxx_w = cx_q * cx_q;
  assign cyy_w = cy_q * cy_q;
  assign czz_w = cz_q * cz_q;
  assign lim   = NW'(se_q) << QW;
  assign dvd[0] = nd_q;
  assign dvd[1] = ni_q;
  assign dvd[2] = no_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pyz_q <= 23'(py_i * dz_i);
      pzy_q <= 23'(pz_i * dy_i);
      pzx_q <= 23'(pz_i * dx_i);
      pxz_q <= 23'(px_i * dz_i);
      pxy_q <= 23'(px_i * dy_i);
      pyx_q <= 23'(py_i * dx_i);
      sqx_q <= sqx_w[22:0];
      sqy_q <= sqy_w[22:0];
      sqz_q <= sqz_w[22:0];

      cx_q <= 24'(pyz_q) - 24'(pzy_q);
      cy_q <= 24'(pzx_q) - 24'(pxz_q);
      cz_q <= 24'(pxy_q) - 24'(pyx_q);
      sb_q <= SW'(sqx_q) + SW'(sqy_q) + SW'(sqz_q);

      cxx_q <= cxx_w[43:0];
      cyy_q <= cyy_w[43:0];
      czz_q <= czz_w[43:0];
      ri2_q <= 20'(ri_i * ri_i);
      ro2_q <= 20'(ro_i * ro_i);
      sc_q  <= sb_q;

      c_q   <= 46'(cxx_q) + 46'(cyy_q) + 46'(czz_q);
      rsi_q <= 44'(ri2_q * sc_q);
      rso_q <= 44'(ro2_q * sc_q);
      sd_q  <= sc_q;

      nd_q <= NW'(c_q) << 8;
      ni_q <= (46'(rsi_q) >= c_q) ? (NW'(46'(rsi_q) - c_q) << 10) : '0;
      no_q <= (46'(rso_q) >= c_q) ? (NW'(46'(rso_q) - c_q) << 10) : '0;
      se_q <= sd_q;

      for (int i = 0; i < LANES; i++) begin
        lanes_o[i].rem <= (dvd[i] >= lim) ? (lim - NW'(1)) : dvd[i];
        lanes_o[i].quo <= '0;
      end
      s_o    <= se_q;
      zero_o <= (se_q == '0);
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/tcs_div_cell.sv -----
// One restoring-division step for all lanes, quotient bit K.
// Depends on tcs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcs_div_cell #(
  parameter int unsigned K = 0
) (
  input  wire                                     clk_i,
  input  wire                                     en_i,
  input  tcs_pkg::div_lane_t [tcs_pkg::LANES-1:0] lanes_i,
  input  wire  [tcs_pkg::SW-1:0]                  s_i,
  output tcs_pkg::div_lane_t [tcs_pkg::LANES-1:0] lanes_o,
  output logic [tcs_pkg::SW-1:0]                  s_o
);
  import tcs_pkg::*;

  logic [NW-1:0] sh;
  assign sh = NW'(s_i) << K;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < LANES; i++) begin
        if (lanes_i[i].rem >= sh) begin
          lanes_o[i].rem <= lanes_i[i].rem - sh;
          lanes_o[i].quo <= lanes_i[i].quo | (QW'(1) << K);
        end else begin
          lanes_o[i] <= lanes_i[i];
        end
      end
      s_o <= s_i;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/tcs_root_cell.sv -----
// One integer square-root step for all lanes, trial bit 4^K.
// Depends on tcs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcs_root_cell #(
  parameter int unsigned K = 0
) (
  input  wire                                      clk_i,
  input  wire                                      en_i,
  input  tcs_pkg::root_lane_t [tcs_pkg::LANES-1:0] lanes_i,
  output tcs_pkg::root_lane_t [tcs_pkg::LANES-1:0] lanes_o
);
  import tcs_pkg::*;

  logic [RW-1:0] bitv;
  logic [RW-1:0] t [LANES];
  assign bitv = RW'(1) << (2 * K);

  always_comb begin
    for (int i = 0; i < LANES; i++) t[i] = lanes_i[i].res + bitv;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < LANES; i++) begin
        if (lanes_i[i].rem >= t[i]) begin
          lanes_o[i].rem <= lanes_i[i].rem - t[i];
          lanes_o[i].res <= (lanes_i[i].res >> 1) + bitv;
        end else begin
          lanes_o[i].rem <= lanes_i[i].rem;
          lanes_o[i].res <= lanes_i[i].res >> 1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/track_chord_through_spheres_top.sv -----
// Top level: config registers, front arithmetic, divide and root cell chains.
// Depends on tcs_pkg, tcs_front, tcs_div_cell, tcs_root_cell.
//
//  channel | signals                               | dir
//  in      | in_valid_i/in_ready_o, entry_*, dir_* | sink
//  out     | out_valid_o/out_ready_i, 4 fields     | source
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i       | sink
//
// Pipeline: 6 front stages, 30 divide cells, 15 root cells, output register.
// One transfer per cycle while the output is not stalled; the whole chain advances together.
// A stalled output freezes the chain; in_ready_o drops only then.
// Reset clears valid flags and sets radii to 650 and 830.
`timescale 1ns / 1ps
`default_nettype none
module track_chord_through_spheres_top (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire                cfg_idx_i,
  input  wire  [9:0]         cfg_data_i,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire  signed [10:0] entry_x_i,
  input  wire  signed [10:0] entry_y_i,
  input  wire  signed [10:0] entry_z_i,
  input  wire  signed [11:0] dir_x_i,
  input  wire  signed [11:0] dir_y_i,
  input  wire  signed [11:0] dir_z_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic [14:0]        axis_distance_o,
  output logic [14:0]        inner_chord_o,
  output logic [14:0]        shell_chord_o,
  output logic               zero_direction_o
);
  import tcs_pkg::*;

  logic [9:0] ri_q, ro_q;
  logic en;
  logic [CORE_LAT-1:0] vld_q;
  logic [QW+RTW-1:0]   zr_q;
  logic zero_f;
  div_lane_t  [LANES-1:0] dv [QW+1];
  logic       [SW-1:0]    sv [QW+1];
  root_lane_t [LANES-1:0] rt [RTW+1];
  logic [LW-1:0] ci, co;

  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ri_q <= INNER_RESET;
      ro_q <= OUTER_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INNER: ri_q <= cfg_data_i;
        REG_OUTER: ro_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tcs_front u_front (
    .clk_i, .en_i(en),
    .px_i(entry_x_i), .py_i(entry_y_i), .pz_i(entry_z_i),
    .dx_i(dir_x_i), .dy_i(dir_y_i), .dz_i(dir_z_i),
    .ri_i(ri_q), .ro_i(ro_q),
    .lanes_o(dv[0]), .s_o(sv[0]), .zero_o(zero_f)
  );

  for (genvar g = 0; g < QW; g++) begin : g_div
    tcs_div_cell #(.K(QW - 1 - g)) u_cell (
      .clk_i, .en_i(en),
      .lanes_i(dv[g]), .s_i(sv[g]),
      .lanes_o(dv[g+1]), .s_o(sv[g+1])
    );
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rt[0][i].rem = RW'(dv[QW][i].quo);
      rt[0][i].res = '0;
    end
  end

  for (genvar g = 0; g < RTW; g++) begin : g_root
    tcs_root_cell #(.K(RTW - 1 - g)) u_cell (
      .clk_i, .en_i(en), .lanes_i(rt[g]), .lanes_o(rt[g+1])
    );
  end

  assign ci = rt[RTW][1].res[LW-1:0];
  assign co = rt[RTW][2].res[LW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[CORE_LAT-2:0], in_valid_i};
      out_valid_o <= vld_q[CORE_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zr_q <= {zr_q[QW+RTW-2:0], zero_f};
      zero_direction_o <= zr_q[QW+RTW-1];
      if (zr_q[QW+RTW-1]) begin
        axis_distance_o <= '0;
        inner_chord_o   <= '0;
        shell_chord_o   <= '0;
      end else begin
        axis_distance_o <= rt[RTW][0].res[LW-1:0];
        inner_chord_o   <= ci;
        shell_chord_o   <= (co > ci) ? (co - ci) : '0;
      end
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/tcs_checker.sv -----
// Port-level checks for the track chord block, bound to its top level.
// Depends on track_chord_through_spheres_top.
`timescale 1ns / 1ps
`default_nettype none
module tcs_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_ready_o,
  input wire        out_valid_o,
  input wire        out_ready_i,
  input wire [14:0] axis_distance_o,
  input wire [14:0] inner_chord_o,
  input wire [14:0] shell_chord_o,
  input wire        zero_direction_o
);
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o) else $error("input stalled with empty output");
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o) else $error("input taken during stall");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_direction_o) |->
      (axis_distance_o == 15'd0 && inner_chord_o == 15'd0 && shell_chord_o == 15'd0))
    else $error("nonzero length with zero direction");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(axis_distance_o)
      && $stable(inner_chord_o) && $stable(shell_chord_o)))
    else $error("output changed under stall");
endmodule

bind track_chord_through_spheres_top tcs_checker u_tcs_checker (.*);
`default_nettype wire
